/* rtl/gb3_pkg.sv */
// Shared types and constants of the 3x3 binomial blur block.
package gb3_pkg;

  // Largest supported row length and the column address width it implies
  localparam int MAX_WIDTH = 2048;
  localparam int COL_W     = $clog2(MAX_WIDTH);

  // Register and field widths
  localparam int FW_W  = 12;
  localparam int FH_W  = 16;
  localparam int ROW_W = FH_W + 1;
  localparam int PIX_W = 8;
  localparam int CFG_W = 16;

  // Reset values of the frame geometry
  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = FW_W'(640);
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(480);

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_index_t;

  // Control of one item handed from the front end to the window stage
  typedef struct packed {
    logic [COL_W-1:0] addr;       // column of the line stores
    logic             use_pix;    // take the arriving pixel, else the middle line
    logic [PIX_W-1:0] pixel;
    logic             emit_a;     // last column of the row two back
    logic             emit_b;     // regular result for the previous column
    logic             do_line;    // update line stores and window
    logic             restart;    // frame done, clear window and result position
    logic             top_mid;    // first row below top: replicate top row
    logic             wide;       // row longer than one pixel
    logic             left_old;   // left column exists in the window
  } gb3_item_t;

  // Write port of the line stores
  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    logic [PIX_W-1:0] above;
    logic [PIX_W-1:0] mid;
  } gb3_wr_t;

  // One result item
  typedef struct packed {
    logic             frame_end;
    logic             row_end;
    logic [PIX_W-1:0] pixel;
  } gb3_result_t;

endpackage

/* rtl/gb3_line_store.sv */
// Two line memories with registered read and write forwarding.
module gb3_line_store (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      rd_en,
  input  logic [gb3_pkg::COL_W-1:0] rd_addr,
  input  gb3_pkg::gb3_wr_t          wr,
  output logic [gb3_pkg::PIX_W-1:0] above,
  output logic [gb3_pkg::PIX_W-1:0] mid
);

  logic [gb3_pkg::PIX_W-1:0] above_mem [gb3_pkg::MAX_WIDTH];
  logic [gb3_pkg::PIX_W-1:0] mid_mem   [gb3_pkg::MAX_WIDTH];
  logic [gb3_pkg::PIX_W-1:0] q_above;
  logic [gb3_pkg::PIX_W-1:0] q_mid;
  logic [gb3_pkg::PIX_W-1:0] fwd_above;
  logic [gb3_pkg::PIX_W-1:0] fwd_mid;
  logic                      hit;

  // Write back and read ahead
  always_ff @(posedge clk) begin
    if (wr.en) begin
      above_mem[wr.addr] <= wr.above;
      mid_mem[wr.addr]   <= wr.mid;
      fwd_above          <= wr.above;
      fwd_mid            <= wr.mid;
    end
    if (rd_en) begin
      q_above <= above_mem[rd_addr];
      q_mid   <= mid_mem[rd_addr];
    end
  end

  // Flag a read that raced a write to the same column
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (rd_en) begin
      hit <= wr.en && (wr.addr == rd_addr);
    end
  end

  assign above = hit ? fwd_above : q_above;
  assign mid   = hit ? fwd_mid   : q_mid;

endmodule

/* rtl/gb3_front.sv */
// Input side: position counters, item classification and line store read.
module gb3_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      restart,
  input  logic [gb3_pkg::FW_W-1:0]  width,
  input  logic [gb3_pkg::FH_W-1:0]  height,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      action,
  input  logic [gb3_pkg::PIX_W-1:0] pixel,
  input  logic                      go,
  output logic                      rd_en,
  output logic [gb3_pkg::COL_W-1:0] rd_addr,
  output logic                      s1_valid,
  output gb3_pkg::gb3_item_t        s1
);

  logic [gb3_pkg::COL_W-1:0] col;
  logic [gb3_pkg::ROW_W-1:0] row;
  logic [gb3_pkg::COL_W-1:0] col_next;
  logic [gb3_pkg::ROW_W-1:0] row_next;
  logic [gb3_pkg::FW_W-1:0]  col_plus;
  logic [gb3_pkg::ROW_W-1:0] h_ext;
  logic                      pix_row;
  logic                      last_row;
  logic                      active;
  gb3_pkg::gb3_item_t        item;

  assign in_ready = !s1_valid || go;
  assign h_ext    = {1'b0, height};
  assign pix_row  = row < h_ext;
  assign last_row = row == (h_ext + gb3_pkg::ROW_W'(1));
  // Drop pixels past the frame and drains inside it
  assign active   = in_valid && in_ready && (pix_row ? !action : action);
  assign col_plus = {1'b0, col} + gb3_pkg::FW_W'(1);

  // Classify the item
  always_comb begin
    item.addr     = col;
    item.use_pix  = pix_row;
    item.pixel    = pixel;
    item.emit_a   = (col == '0) && (row >= gb3_pkg::ROW_W'(2));
    item.emit_b   = !last_row && (col != '0) && (row != '0);
    item.do_line  = !last_row;
    item.restart  = last_row;
    item.top_mid  = row == gb3_pkg::ROW_W'(1);
    item.wide     = width >= gb3_pkg::FW_W'(2);
    item.left_old = col >= gb3_pkg::COL_W'(2);
  end

  // Advance the raster position
  always_comb begin
    col_next = col;
    row_next = row;
    if (active) begin
      if (last_row) begin
        col_next = '0;
        row_next = '0;
      end else if (col_plus == width) begin
        col_next = '0;
        row_next = row + gb3_pkg::ROW_W'(1);
      end else begin
        col_next = col_plus[gb3_pkg::COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col      <= '0;
      row      <= '0;
      s1_valid <= 1'b0;
    end else begin
      col <= col_next;
      row <= row_next;
      if (active) begin
        s1_valid <= 1'b1;
      end else if (go) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // Hold the item while the window stage stalls
  always_ff @(posedge clk) begin
    if (active) begin
      s1 <= item;
    end
  end

  assign rd_en   = active;
  assign rd_addr = col;

endmodule

/* rtl/gb3_window.sv */
// Window stage: column assembly, line write back, 3x3 sum and result position.
module gb3_window (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      restart,
  input  logic [gb3_pkg::FW_W-1:0]  width,
  input  logic [gb3_pkg::FH_W-1:0]  height,
  input  logic                      go,
  input  gb3_pkg::gb3_item_t        s1,
  input  logic [gb3_pkg::PIX_W-1:0] above,
  input  logic [gb3_pkg::PIX_W-1:0] mid,
  output gb3_pkg::gb3_wr_t          wr,
  output logic                      push,
  output gb3_pkg::gb3_result_t      result
);

  logic [gb3_pkg::PIX_W-1:0] older [3];
  logic [gb3_pkg::PIX_W-1:0] newer [3];
  logic [gb3_pkg::PIX_W-1:0] cur   [3];
  logic [gb3_pkg::PIX_W-1:0] lft   [3];
  logic [gb3_pkg::PIX_W-1:0] rgt   [3];
  logic [9:0]                row_sum [3];
  logic [12:0]               total;
  logic [gb3_pkg::PIX_W-1:0] val;
  logic [gb3_pkg::COL_W-1:0] out_col;
  logic [gb3_pkg::FH_W-1:0]  out_row;
  logic                      rend;
  logic                      fend;

  // Build the current column, clamped at the top
  assign val    = s1.use_pix ? s1.pixel : mid;
  assign cur[0] = s1.top_mid ? mid : above;
  assign cur[1] = mid;
  assign cur[2] = val;

  // Pick left and right columns, replicating at the row ends
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (s1.emit_a) begin
        lft[i] = s1.wide ? older[i] : newer[i];
        rgt[i] = newer[i];
      end else begin
        lft[i] = s1.left_old ? older[i] : newer[i];
        rgt[i] = cur[i];
      end
      row_sum[i] = 10'(lft[i]) + {1'b0, newer[i], 1'b0} + 10'(rgt[i]);
    end
    total = 13'(row_sum[0]) + {2'b0, row_sum[1], 1'b0} + 13'(row_sum[2]) + 13'd8;
  end

  assign rend = {1'b0, out_col} == (width - gb3_pkg::FW_W'(1));
  assign fend = rend && (out_row == (height - gb3_pkg::FH_W'(1)));

  assign push             = go && (s1.emit_a || s1.emit_b);
  assign result.pixel     = total[11:4];
  assign result.row_end   = rend;
  assign result.frame_end = fend;

  // Write back the shifted column
  assign wr.en    = go && s1.do_line;
  assign wr.addr  = s1.addr;
  assign wr.above = mid;
  assign wr.mid   = val;

  // Slide the window
  always_ff @(posedge clk) begin
    if (rst || restart || (go && s1.restart)) begin
      for (int i = 0; i < 3; i++) begin
        older[i] <= '0;
        newer[i] <= '0;
      end
    end else if (go && s1.do_line) begin
      for (int i = 0; i < 3; i++) begin
        older[i] <= newer[i];
        newer[i] <= cur[i];
      end
    end
  end

  // Track the raster position of the next result
  always_ff @(posedge clk) begin
    if (rst || restart || (go && s1.restart)) begin
      out_col <= '0;
      out_row <= '0;
    end else if (push) begin
      if (rend) begin
        out_col <= '0;
        out_row <= out_row + gb3_pkg::FH_W'(1);
      end else begin
        out_col <= out_col + gb3_pkg::COL_W'(1);
      end
    end
  end

endmodule

/* rtl/gb3_out_queue.sv */
// Two-entry output queue that decouples the result stream from the pipeline.
module gb3_out_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  gb3_pkg::gb3_result_t push_data,
  output logic                 full,
  output logic                 out_valid,
  input  logic                 out_ready,
  output gb3_pkg::gb3_result_t out_data
);

  gb3_pkg::gb3_result_t entries [2];
  logic                 wr_ptr;
  logic                 rd_ptr;
  logic [1:0]           count;
  logic                 pop;

  assign full      = count == 2'd2;
  assign out_valid = count != 2'd0;
  assign out_data  = entries[rd_ptr];
  assign pop       = out_valid && out_ready;

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full || pop)
    else $error("item pushed into a full output queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("output queue occupancy out of range");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> count == $past(count) - 2'd1)
    else $error("output queue lost track of a popped item");
`endif

endmodule

/* rtl/gaussian_blur_3x3_replicate.sv */
// Top level of the streaming 3x3 binomial blur with replicated borders.
//
// Usage: set frame_width (index 0) and frame_height (index 1) on the cfg
// channel while the block is idle; each write restarts the frame count.
// Pixels arrive on the s_ channel in raster order: s_tdata[7:0] holds the
// pixel and s_tuser is 0. After the frame, send frame_width + 1 drain items
// (s_tuser = 1) to flush the last results. Drains inside a frame and pixels
// after the frame's last pixel are taken and dropped.
// Results leave on the m_ channel in raster order: m_tdata[7:0] is the
// blurred pixel, m_tlast marks the last pixel of a row, m_tuser the last
// pixel of the frame. Result n is caused by input item n + width + 1, which
// waits in the item register while the output queue is full. Throughput
// is otherwise one item per clock: each item does one read and one write
// of both line stores at its column, and the next item's read overlaps the
// previous item's write, with forwarding when both hit the same column.
// A stalled receiver fills a two-entry output queue; s_tready then drops
// until space returns. Reset clears counters, the window and the queue and
// loads 640 x 480; the line stores are not cleared.
module gaussian_blur_3x3_replicate (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [7:0]                s_tdata,   // [7:0] in_pixel
  input  logic                      s_tuser,   // [0] action
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [7:0]                m_tdata,   // [7:0] out_pixel
  output logic                      m_tlast,   // row_end
  output logic                      m_tuser,   // [0] frame_end
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [0:0]                cfg_index,
  input  logic [gb3_pkg::CFG_W-1:0] cfg_data
);

  logic [gb3_pkg::FW_W-1:0]  frame_width;
  logic [gb3_pkg::FH_W-1:0]  frame_height;
  logic [gb3_pkg::FW_W-1:0]  width;
  logic [gb3_pkg::FH_W-1:0]  height;
  logic                      restart;
  logic                      go;
  logic                      full;
  logic                      rd_en;
  logic [gb3_pkg::COL_W-1:0] rd_addr;
  logic                      s1_valid;
  gb3_pkg::gb3_item_t        s1;
  gb3_pkg::gb3_wr_t          wr;
  logic [gb3_pkg::PIX_W-1:0] above;
  logic [gb3_pkg::PIX_W-1:0] mid;
  logic                      push;
  gb3_pkg::gb3_result_t      result;
  gb3_pkg::gb3_result_t      out_data;

  assign cfg_ready = 1'b1;
  assign restart   = cfg_valid;

  // Load the geometry registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= gb3_pkg::FRAME_WIDTH_RST;
      frame_height <= gb3_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_valid) begin
      case (gb3_pkg::cfg_index_t'(cfg_index))
        gb3_pkg::CFG_FRAME_WIDTH:  frame_width  <= cfg_data[gb3_pkg::FW_W-1:0];
        gb3_pkg::CFG_FRAME_HEIGHT: frame_height <= cfg_data;
        default:                   frame_width  <= frame_width;
      endcase
    end
  end

  // Clamp width to 1..MAX_WIDTH and height to at least 1
  always_comb begin
    if (frame_width == '0) begin
      width = gb3_pkg::FW_W'(1);
    end else if (frame_width > gb3_pkg::FW_W'(gb3_pkg::MAX_WIDTH)) begin
      width = gb3_pkg::FW_W'(gb3_pkg::MAX_WIDTH);
    end else begin
      width = frame_width;
    end
    height = (frame_height == '0) ? gb3_pkg::FH_W'(1) : frame_height;
  end

  assign go = s1_valid && !full;

  gb3_front u_front (
    .clk      (clk),
    .rst      (rst),
    .restart  (restart),
    .width    (width),
    .height   (height),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .action   (s_tuser),
    .pixel    (s_tdata),
    .go       (go),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .s1_valid (s1_valid),
    .s1       (s1)
  );

  gb3_line_store u_lines (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr      (wr),
    .above   (above),
    .mid     (mid)
  );

  gb3_window u_window (
    .clk     (clk),
    .rst     (rst),
    .restart (restart),
    .width   (width),
    .height  (height),
    .go      (go),
    .s1      (s1),
    .above   (above),
    .mid     (mid),
    .wr      (wr),
    .push    (push),
    .result  (result)
  );

  gb3_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (result),
    .full      (full),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_data)
  );

  assign m_tdata = out_data.pixel;
  assign m_tlast = out_data.row_end;
  assign m_tuser = out_data.frame_end;

endmodule

/* verif/gaussian_blur_3x3_replicate_tb.sv */
// Self-checking testbench of the 3x3 binomial blur with replicated borders.
`timescale 1ns / 100ps

module gaussian_blur_3x3_replicate_tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int PRINT_CAP      = 50;

  // Input item kinds on s_tuser
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  // One column of the window, already clamped at the top border
  typedef struct packed {
    logic [gb3_pkg::PIX_W-1:0] bottom;
    logic [gb3_pkg::PIX_W-1:0] middle;
    logic [gb3_pkg::PIX_W-1:0] top;
  } column_t;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [7:0]                s_tdata = '0;     // [7:0] in_pixel
  logic                      s_tuser = 1'b0;   // [0] action
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [7:0]                m_tdata;          // [7:0] out_pixel
  logic                      m_tlast;          // row_end
  logic                      m_tuser;          // [0] frame_end
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [0:0]                cfg_index = '0;
  logic [gb3_pkg::CFG_W-1:0] cfg_data = '0;

  // Predictor state
  logic [gb3_pkg::FW_W-1:0]  reg_width_q  = gb3_pkg::FRAME_WIDTH_RST;
  logic [gb3_pkg::FH_W-1:0]  reg_height_q = gb3_pkg::FRAME_HEIGHT_RST;
  logic [gb3_pkg::PIX_W-1:0] row_two_up [gb3_pkg::MAX_WIDTH];
  logic [gb3_pkg::PIX_W-1:0] row_one_up [gb3_pkg::MAX_WIDTH];
  column_t                   win_back2 = '0;
  column_t                   win_back1 = '0;
  int                        in_col  = 0;
  int                        in_row  = 0;
  int                        out_col = 0;
  int                        out_row = 0;
  gb3_pkg::gb3_result_t      blur_expected [$];

  // Test control
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int hold_left      = 0;
  int items_sent     = 0;
  int mismatch_count = 0;
  int quiet_cycles   = 0;

  gaussian_blur_3x3_replicate DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int eff_width();
    if (reg_width_q == 0) return 1;
    if (reg_width_q > gb3_pkg::MAX_WIDTH) return gb3_pkg::MAX_WIDTH;
    return int'(reg_width_q);
  endfunction

  function automatic int eff_height();
    return (reg_height_q == 0) ? 1 : int'(reg_height_q);
  endfunction

  function automatic void restart_count();
    in_col    = 0;
    in_row    = 0;
    out_col   = 0;
    out_row   = 0;
    win_back2 = '0;
    win_back1 = '0;
  endfunction

  // Weight three columns by [1,2,1] both ways, round and queue the pixel
  function automatic void emit_blur(column_t l, column_t c, column_t r, int w, int h);
    int                   s;
    gb3_pkg::gb3_result_t res;
    s = int'(l.top) + 2 * int'(c.top) + int'(r.top)
      + 2 * (int'(l.middle) + 2 * int'(c.middle) + int'(r.middle))
      + int'(l.bottom) + 2 * int'(c.bottom) + int'(r.bottom);
    res.pixel     = 8'((s + 8) >> 4);
    res.row_end   = (out_col == w - 1);
    res.frame_end = res.row_end && (out_row == h - 1);
    blur_expected.push_back(res);
    if (res.row_end) begin
      out_col = 0;
      out_row++;
    end else begin
      out_col++;
    end
  endfunction

  function automatic void blur_predict(logic action, logic [gb3_pkg::PIX_W-1:0] pix);
    int                        w, h, ic, ir;
    logic [gb3_pkg::PIX_W-1:0] above, mid, val;
    column_t                   col;
    w  = eff_width();
    h  = eff_height();
    ic = (in_col >= w) ? w - 1 : in_col;
    ir = in_row;
    // Drop drains inside the frame and pixels during the flush
    if (ir < h) begin
      if (action == ACT_DRAIN) return;
      val = pix;
    end else begin
      if (action == ACT_PIXEL) return;
      val = row_one_up[ic];
    end
    // A new row closes the row two back: right neighbor repeats the center
    if (ic == 0 && ir >= 2)
      emit_blur((w >= 2) ? win_back2 : win_back1, win_back1, win_back1, w, h);
    if (ir >= h + 1) begin
      restart_count();
      return;
    end
    above          = row_two_up[ic];
    mid            = row_one_up[ic];
    row_two_up[ic] = mid;
    row_one_up[ic] = val;
    col.top        = (ir == 1) ? mid : above;
    col.middle     = mid;
    col.bottom     = val;
    if (ic >= 1 && ir >= 1)
      emit_blur((ic >= 2) ? win_back2 : win_back1, win_back1, col, w, h);
    win_back2 = win_back1;
    win_back1 = col;
    ic++;
    if (ic >= w) begin
      ic = 0;
      ir++;
    end
    in_col = ic;
    in_row = ir;
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (mismatch_count < PRINT_CAP)
      $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Offer one item after random idle cycles; keep tvalid high on exit
  task automatic send_item(input logic action, input logic [gb3_pkg::PIX_W-1:0] pix);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= action;
    s_tdata  <= pix;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    blur_predict(action, pix);
    items_sent++;
  endtask

  // Stop offering, wait for all results, then let items with no result drain
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (blur_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input gb3_pkg::cfg_index_t idx,
                           input logic [gb3_pkg::CFG_W-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == gb3_pkg::CFG_FRAME_WIDTH) reg_width_q = value[gb3_pkg::FW_W-1:0];
    else reg_height_q = value[gb3_pkg::FH_W-1:0];
    restart_count();
  endtask

  // Width carries random junk above its 12 bits
  task automatic set_geometry(input int w, input int h);
    write_reg(gb3_pkg::CFG_FRAME_WIDTH, {4'($urandom), 12'(w)});
    write_reg(gb3_pkg::CFG_FRAME_HEIGHT, 16'(h));
  endtask

  // Send a frame and its flush; stop after cut_at pixels when cut_at >= 0
  task automatic send_frame(input int noise_pct, input int cut_at);
    int w, h, i;
    w = eff_width();
    h = eff_height();
    for (i = 0; i < w * h; i++) begin
      if (i == cut_at) return;
      if ($urandom_range(99) < noise_pct) send_item(ACT_DRAIN, 8'($urandom));
      send_item(ACT_PIXEL, 8'($urandom));
    end
    for (i = 0; i <= w; i++) begin
      if ($urandom_range(99) < noise_pct) send_item(ACT_PIXEL, 8'($urandom));
      send_item(ACT_DRAIN, 8'($urandom));
    end
    if ($urandom_range(99) < noise_pct) send_item(ACT_DRAIN, 8'($urandom));
  endtask

  // ---------------------------------------------------------------- tests

  // Reset geometry: a short stretch of a 640-pixel row gives no result
  task automatic test_reset_geometry();
    int i;
    for (i = 0; i < 50; i++) send_item(ACT_PIXEL, 8'($urandom));
  endtask

  // Tiny frame with extreme pixels and every kind of ignored item
  task automatic test_directed_frame();
    set_geometry(3, 2);
    send_item(ACT_DRAIN, 8'hA5);   // drain before any pixel
    send_item(ACT_PIXEL, 8'h00);
    send_item(ACT_PIXEL, 8'hFF);
    send_item(ACT_PIXEL, 8'h00);
    send_item(ACT_DRAIN, 8'h5A);   // drain in mid frame
    send_item(ACT_PIXEL, 8'hFF);
    send_item(ACT_PIXEL, 8'hFF);
    send_item(ACT_PIXEL, 8'h00);
    send_item(ACT_PIXEL, 8'h80);   // pixel during the flush
    repeat (4) send_item(ACT_DRAIN, 8'h00);
    repeat (2) send_item(ACT_DRAIN, 8'hFF);   // drains after the flush
  endtask

  // Zero width and height clamp to a single pixel frame
  task automatic test_degenerate_geometry();
    set_geometry(0, 0);
    send_item(ACT_PIXEL, 8'hFF);
    send_item(ACT_DRAIN, 8'h00);
    send_item(ACT_DRAIN, 8'h00);
  endtask

  // Saturated width cut short, then the tallest frame cut short
  task automatic test_extreme_geometry();
    set_geometry(4095, 1);
    send_frame(0, 50);
    set_geometry(2, 65535);
    send_frame(0, 12);
  endtask

  // Hold the receiver off long enough that the block stalls its input
  task automatic test_backpressure();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    set_geometry(8, 4);
    @(negedge clk);
    hold_left = 300;
    @(posedge clk);
    send_frame(0, -1);
  endtask

  // Random geometry per frame with some noise and aborted frames
  task automatic test_random_frames(input int idle_pct, input int stall_pct,
                                    input int n_items);
    int stop_at, w_reg, h_reg, cut;
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    stop_at        = items_sent + n_items;
    while (items_sent < stop_at) begin
      w_reg = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      h_reg = $urandom_range(0, 6);
      set_geometry(w_reg, h_reg);
      cut = -1;
      if ($urandom_range(99) < 8) cut = $urandom_range(0, eff_width() * eff_height() - 1);
      send_frame(10, cut);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_geometry();
    test_directed_frame();
    test_degenerate_geometry();
    test_extreme_geometry();
    test_backpressure();
    test_random_frames(0, 0, 80);
    test_random_frames(55, 0, 80);
    test_random_frames(0, 55, 80);
    test_random_frames(21, 21, 80);
    wait_idle();
    if (mismatch_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- monitors

  // Receiver: long hold-off when requested, else random stalls
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin : result_check
    gb3_pkg::gb3_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (blur_expected.size() == 0) begin
        report_mismatch("result with none expected", m_tdata, 8'h00);
      end else begin
        want = blur_expected.pop_front();
        if (m_tdata !== want.pixel) report_mismatch("out_pixel", m_tdata, want.pixel);
        if (m_tlast !== want.row_end)
          report_mismatch("row_end", 8'(m_tlast), 8'(want.row_end));
        if (m_tuser !== want.frame_end)
          report_mismatch("frame_end", 8'(m_tuser), 8'(want.frame_end));
      end
    end
  end

  // End the run when no channel moves an item for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

/* filelist.f */
rtl/gb3_pkg.sv
rtl/gb3_line_store.sv
rtl/gb3_front.sv
rtl/gb3_window.sv
rtl/gb3_out_queue.sv
rtl/gaussian_blur_3x3_replicate.sv
verif/gaussian_blur_3x3_replicate_tb.sv
